/* design/tmpbd_pkg.sv */
// Shared types and constants for the tape period bit decoder.
package tmpbd_pkg;

  // Configuration register indexes
  localparam logic [1:0] RegFloorLevel    = 2'd0;
  localparam logic [1:0] RegSwingThresh   = 2'd1;
  localparam logic [1:0] RegZeroGapMin    = 2'd2;
  localparam logic [1:0] RegOneGapAbove   = 2'd3;

  localparam int unsigned AddrBits = 4;
  localparam int unsigned DataBits = 32;
  localparam int unsigned PeriodBits = 32;

  // Reset values
  localparam logic [14:0] FloorLevelRst  = 15'd1638;
  localparam logic [15:0] SwingThreshRst = 16'd10922;
  localparam logic [15:0] ZeroGapMinRst  = 16'd18;
  localparam logic [15:0] OneGapAboveRst = 16'd30;

  // One decoded word
  typedef struct packed {
    logic                  bit_value;
    logic [PeriodBits-1:0] period;
  } result_t;

endpackage

/* design/tape_min_period_bit_decoder.sv */
// Tape period bit decoder: zero-crossing tracker, period classifier and output buffer.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o / sample_i) takes one signed audio
//   sample word per cycle while in_ready_o is high. Output channel (out_valid_o
//   / out_ready_i / bit_value_o / period_o) delivers one decoded bit word per
//   qualifying rising zero crossing, with the minimum-to-minimum distance behind it.
//   Throughput: one sample per cycle while in_ready_o is high; the crossing
//   and min/max state update in a single pass between the input handshake
//   and the result register, or the skid register while that one is full.
//   A two-entry output buffer (result register plus skid register) lets the
//   block keep taking samples while one result waits; in_ready_o drops only
//   while both entries are full, and rises again once the receiver takes one.
//   The APB port (psel, penable, pwrite, paddr, pwdata, prdata, pready) holds
//   floor_level, swing_threshold, zero_gap_min and one_gap_above at byte
//   addresses 0, 4, 8 and 12; pready is always high, writes take effect on
//   the access cycle; the user must write it only while the block is idle (not enforced).
//   Reset (rst_ni low, asynchronous) clears the tracking state and the output
//   buffer and loads the register defaults; the first sample after reset
//   only primes the previous-sample register.
module tape_min_period_bit_decoder #(
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned INDEX_BITS  = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // sample channel
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0]       sample_i,
  // result channel
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                bit_value_o,
  output logic signed [tmpbd_pkg::PeriodBits-1:0] period_o,
  // configuration
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [tmpbd_pkg::AddrBits-1:0]      paddr,
  input  logic [tmpbd_pkg::DataBits-1:0]      pwdata,
  output logic [tmpbd_pkg::DataBits-1:0]      prdata,
  output logic                                pready
);
  import tmpbd_pkg::*;

  // compare width: holds max - min and -floor_level without overflow
  localparam int unsigned CW = ((SAMPLE_BITS > 16) ? SAMPLE_BITS : 16) + 2;

  // configuration registers
  logic [14:0] floor_level_q;
  logic [15:0] swing_threshold_q;
  logic [15:0] zero_gap_min_q;
  logic [15:0] one_gap_above_q;
  logic        cfg_wr;
  logic [1:0]  cfg_idx;

  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[3:2];
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      floor_level_q     <= FloorLevelRst;
      swing_threshold_q <= SwingThreshRst;
      zero_gap_min_q    <= ZeroGapMinRst;
      one_gap_above_q   <= OneGapAboveRst;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        RegFloorLevel:  floor_level_q     <= pwdata[14:0];
        RegSwingThresh: swing_threshold_q <= pwdata[15:0];
        RegZeroGapMin:  zero_gap_min_q    <= pwdata[15:0];
        RegOneGapAbove: one_gap_above_q   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      RegFloorLevel:  prdata = DataBits'(floor_level_q);
      RegSwingThresh: prdata = DataBits'(swing_threshold_q);
      RegZeroGapMin:  prdata = DataBits'(zero_gap_min_q);
      RegOneGapAbove: prdata = DataBits'(one_gap_above_q);
      default:        prdata = '0;
    endcase
  end

  // tracking state
  logic                          primed_q;
  logic signed [SAMPLE_BITS-1:0] prev_sample_q, prev_sample_d;
  logic signed [SAMPLE_BITS-1:0] run_max_q, run_max_d;
  logic signed [SAMPLE_BITS-1:0] run_min_q, run_min_d;
  logic [INDEX_BITS-1:0]         sample_index_q;
  logic [INDEX_BITS-1:0]         min_pos_q, min_pos_d;
  logic [INDEX_BITS-1:0]         prev_min_pos_q, prev_min_pos_d;

  logic                  in_fire;
  logic                  rise, fall, below_floor, swing_ok;
  logic [INDEX_BITS-1:0] gap;
  logic signed [CW-1:0]  swing;
  logic                  has_result;
  result_t               new_res;

  assign in_fire = in_valid_i && in_ready_o;

  always_comb begin
    rise        = (prev_sample_q <= 0) && (sample_i > 0);
    fall        = (prev_sample_q > 0) && (sample_i <= 0);
    below_floor = CW'(run_min_q) < -$signed(CW'(floor_level_q));
    swing       = CW'(run_max_q) - CW'(run_min_q);
    swing_ok    = swing > $signed(CW'(swing_threshold_q));
    gap         = min_pos_q - prev_min_pos_q;

    has_result        = 1'b0;
    new_res.bit_value = 1'b0;
    new_res.period    = PeriodBits'(gap);
    if (primed_q && rise && below_floor && swing_ok) begin
      if (gap >= INDEX_BITS'(zero_gap_min_q) && gap < INDEX_BITS'(one_gap_above_q)) begin
        has_result = 1'b1;
      end else if (gap > INDEX_BITS'(one_gap_above_q)) begin
        has_result        = 1'b1;
        new_res.bit_value = 1'b1;
      end
    end

    run_max_d      = run_max_q;
    run_min_d      = run_min_q;
    min_pos_d      = min_pos_q;
    prev_min_pos_d = prev_min_pos_q;
    if (rise && below_floor) begin
      run_max_d = sample_i;
    end else if (fall && below_floor) begin
      run_min_d      = prev_sample_q;
      prev_min_pos_d = min_pos_q;
      min_pos_d      = sample_index_q;
    end
    if (sample_i > run_max_d) run_max_d = sample_i;
    if (sample_i < run_min_d) begin
      run_min_d = sample_i;
      min_pos_d = sample_index_q;
    end
    prev_sample_d = sample_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      primed_q       <= 1'b0;
      prev_sample_q  <= '0;
      run_max_q      <= '0;
      run_min_q      <= '0;
      sample_index_q <= '0;
      min_pos_q      <= '0;
      prev_min_pos_q <= '0;
    end else if (in_fire) begin
      primed_q      <= 1'b1;
      prev_sample_q <= prev_sample_d;
      if (primed_q) begin
        run_max_q      <= run_max_d;
        run_min_q      <= run_min_d;
        min_pos_q      <= min_pos_d;
        prev_min_pos_q <= prev_min_pos_d;
        sample_index_q <= sample_index_q + 1'b1;
      end
    end
  end

  // output buffer: result register plus skid register
  logic    out_valid_q, skid_valid_q;
  result_t out_q, skid_q;
  logic    push, pop;

  assign in_ready_o = !skid_valid_q;
  assign push       = in_fire && has_result;
  assign pop        = out_valid_q && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) begin
        skid_valid_q <= 1'b0;
      end
    end else if (out_valid_q && !pop) begin
      if (push) skid_valid_q <= 1'b1;
    end else begin
      out_valid_q <= push;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) out_q <= skid_q;
    end else if (out_valid_q && !pop) begin
      if (push) skid_q <= new_res;
    end else if (push) begin
      out_q <= new_res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign bit_value_o = out_q.bit_value;
  assign period_o    = $signed(out_q.period);

endmodule
